// ===== rtl/oscillator_trim_search_defines.svh =====
// Assertion helpers for the trim search block.
`ifndef OSCILLATOR_TRIM_SEARCH_DEFINES_SVH
`define OSCILLATOR_TRIM_SEARCH_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define OTS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ots assertion failed");

// Next-cycle implication, disabled while in reset.
`define OTS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ots assertion failed");

`endif

// ===== rtl/ots_pkg.sv =====
package ots_pkg;

	localparam int unsigned TRIM_W   = 8;
	localparam int unsigned WEIGHT_W = 7;
	localparam int unsigned FRAME_W  = 16;

	localparam logic [FRAME_W-1:0]  TARGET_RESET  = 16'd2356;
	localparam logic [FRAME_W-1:0]  INIT_DEV      = 16'd9999;
	localparam logic [WEIGHT_W-1:0] FIRST_WEIGHT  = 7'd64;
	localparam logic [TRIM_W-1:0]   LOWER_BASE    = 8'd0;
	localparam logic [TRIM_W-1:0]   UPPER_BASE    = 8'd128;

	localparam logic MODE_START   = 1'b0;
	localparam logic MODE_MEASURE = 1'b1;

	typedef struct packed {
		logic                searching;
		logic                upper;
		logic [WEIGHT_W-1:0] weight;
		logic [TRIM_W-1:0]   trial;
		logic [TRIM_W-1:0]   best_trim;
		logic [FRAME_W-1:0]  best_dev;
	} search_state_t;

	typedef struct packed {
		logic [TRIM_W-1:0] trim;
		logic              done;
		logic              accepted;
	} step_result_t;

	localparam search_state_t STATE_RESET = '{
		searching: 1'b0,
		upper:     1'b0,
		weight:    FIRST_WEIGHT,
		trial:     '0,
		best_trim: '0,
		best_dev:  INIT_DEV
	};

endpackage

// ===== rtl/ots_step.sv =====
module ots_step (
	input  ots_pkg::search_state_t         cur,
	input  logic                           mode,
	input  logic [ots_pkg::FRAME_W-1:0]    frame_length,
	input  logic [ots_pkg::FRAME_W-1:0]    target,
	output ots_pkg::search_state_t         nxt,
	output ots_pkg::step_result_t          res
);
	import ots_pkg::*;

	logic [FRAME_W:0]      diff;
	logic                  too_short;
	logic [FRAME_W-1:0]    dev;
	logic                  better;
	logic [WEIGHT_W-1:0]   half;
	logic [TRIM_W-1:0]     half_ext;
	logic [TRIM_W-1:0]     first_ext;
	logic                  tgt_nz;

	assign diff      = {1'b0, frame_length} - {1'b0, target};
	assign too_short = diff[FRAME_W];
	assign dev       = too_short ? (~diff[FRAME_W-1:0] + 1'b1) : diff[FRAME_W-1:0];
	assign better    = dev < cur.best_dev;
	assign half      = cur.weight >> 1;
	assign half_ext  = {1'b0, half};
	assign first_ext = {1'b0, FIRST_WEIGHT};
	// first trial of a region steps up from the base when the target is nonzero, down otherwise
	assign tgt_nz    = |target;

	always_comb begin
		nxt          = cur;
		res.trim     = cur.best_trim;
		res.done     = 1'b0;
		res.accepted = 1'b1;
		if (mode == MODE_START) begin
			nxt.searching = 1'b1;
			nxt.upper     = 1'b0;
			nxt.weight    = FIRST_WEIGHT;
			nxt.best_trim = '0;
			nxt.best_dev  = INIT_DEV;
			nxt.trial     = tgt_nz ? (LOWER_BASE + first_ext) : (LOWER_BASE - first_ext);
			res.trim      = nxt.trial;
		end else if (!cur.searching) begin
			res.accepted = 1'b0;
		end else begin
			if (better) begin
				nxt.best_trim = cur.trial;
				nxt.best_dev  = dev;
			end
			if (half == '0) begin
				nxt.weight = FIRST_WEIGHT;
				if (!cur.upper) begin
					nxt.upper = 1'b1;
					nxt.trial = tgt_nz ? (UPPER_BASE + first_ext)
						: (UPPER_BASE - first_ext);
					res.trim  = nxt.trial;
				end else begin
					nxt.searching = 1'b0;
					res.trim      = nxt.best_trim;
					res.done      = 1'b1;
				end
			end else begin
				nxt.weight = half;
				nxt.trial  = too_short ? (cur.trial + half_ext) : (cur.trial - half_ext);
				res.trim   = nxt.trial;
			end
		end
	end

endmodule

// ===== rtl/oscillator_trim_search.sv =====
// Successive-approximation oscillator trim search, two 7-step regions.
// The input register takes the request, then the result register loads once the output
// can accept it. Throughput: one request per cycle unless the output stalls.
// State updates as an item leaves stage 1.
// Reset (arst_n low, async): idle, best trim 0, best deviation 9999, target 2356.
`include "oscillator_trim_search_defines.svh"

module oscillator_trim_search (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [ots_pkg::FRAME_W-1:0]   cfg_wdata,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [15:0]                   s_axis_tdata,  // [15:0] frame_length
	input  logic                          s_axis_tuser,  // [0] mode
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [7:0]                    m_axis_tdata,  // [7:0] trim_value
	output logic [1:0]                    m_axis_tuser   // [0] done_res, [1] accepted
);
	import ots_pkg::*;

	logic [FRAME_W-1:0] target_q;
	search_state_t      state_q;
	search_state_t      state_nxt;
	step_result_t       res;

	logic               valid_s1;
	logic               mode_s1;
	logic [FRAME_W-1:0] frame_s1;

	logic               valid_s2;
	step_result_t       res_s2;

	logic               advance;
	logic               take_in;

	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign take_in       = s_axis_tvalid && s_axis_tready;

	ots_step u_step (
		.cur          (state_q),
		.mode         (mode_s1),
		.frame_length (frame_s1),
		.target       (target_q),
		.nxt          (state_nxt),
		.res          (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= TARGET_RESET;
			state_q  <= STATE_RESET;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (cfg_we) begin
				target_q <= cfg_wdata;
			end
			if (advance) begin
				state_q <= state_nxt;
			end
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (!valid_s2 || m_axis_tready) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			mode_s1  <= s_axis_tuser;
			frame_s1 <= s_axis_tdata;
		end
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = res_s2.trim;
	assign m_axis_tuser  = {res_s2.accepted, res_s2.done};

	`OTS_ASSERT_IMP(a_weight_onehot, clk, arst_n, 1'b1, $onehot(state_q.weight))
	`OTS_ASSERT_IMP(a_idle_weight, clk, arst_n, !state_q.searching,
		state_q.weight == FIRST_WEIGHT)
	`OTS_ASSERT_IMP(a_done_accepted, clk, arst_n, valid_s2 && res_s2.done, res_s2.accepted)
	`OTS_ASSERT_NXT(a_result_follows, clk, arst_n, advance, valid_s2)
	`OTS_ASSERT_NXT(a_start_searches, clk, arst_n, advance && (mode_s1 == MODE_START),
		state_q.searching && !res_s2.done)

endmodule
